// File: rtl/core/dvn_pkg.sv
// Package for the direction vector normalizer: request/result types and
// the fixed widths shared by the pipeline stages. No dependencies.
`default_nettype none
package dvn_pkg;

    localparam int COORD_W  = 32;              // coordinate width, Q15.16
    localparam int FRAC_W   = 30;              // fraction bits of a unit component
    localparam int UNIT_W   = FRAC_W + 2;      // signed unit component width
    localparam int DIFF_W   = COORD_W + 1;     // exact difference width
    localparam int POS_W    = $clog2(DIFF_W);  // index of a bit of a difference
    localparam int NORM_W   = 31;              // normalised magnitude, top bit at 30
    localparam int NORM_TOP = NORM_W - 1;
    localparam int SQ_W     = 2 * NORM_W;      // one squared magnitude
    localparam int SUM_W    = 64;              // sum of three squares
    localparam int ROOT_W   = SUM_W - 1;       // floor sqrt of sum * 2^62
    localparam int TOP_SH   = SUM_W / 2 - 2;   // scale of m in the first partial remainder
    localparam int QUOT_W   = FRAC_W + 2;      // quotient bits of one division

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } t_req;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic                     zero_length;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/core/dvn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dvn_pkg for SUM_W and ROOT_W.
`default_nettype none
module dvn_isqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [SIDE_W-1:0]          i_side,
    input  wire logic [dvn_pkg::SUM_W-1:0]  i_radicand,
    output logic                            o_valid,
    output logic [SIDE_W-1:0]               o_side,
    output logic [dvn_pkg::ROOT_W-1:0]      o_root
);
    import dvn_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    // The radicand is S * 2^62: its pairs come from S first, then zeros.
    logic                r_vld  [ROOT_W];
    logic [SIDE_W-1:0]   r_side [ROOT_W];
    logic [SUM_W-1:0]    r_rad  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        logic              vld_s;
        logic [SIDE_W-1:0] side_s;
        logic [SUM_W-1:0]  rad_s;
        logic [ROOT_W-1:0] root_s;
        logic [REM_W-1:0]  rem_s;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              fit;
        logic [REM_W-1:0]  n_rem;

        if (g == 0) begin : g_first
            assign vld_s  = i_valid;
            assign side_s = i_side;
            assign rad_s  = i_radicand;
            assign root_s = '0;
            assign rem_s  = '0;
        end else begin : g_next
            assign vld_s  = r_vld[g-1];
            assign side_s = r_side[g-1];
            assign rad_s  = r_rad[g-1];
            assign root_s = r_root[g-1];
            assign rem_s  = r_rem[g-1];
        end

        assign cur   = {rem_s, rad_s[SUM_W-1 -: 2]};
        assign trial = {2'b00, root_s, 2'b01};
        assign fit   = (cur >= trial);

        always_comb begin
            logic [REM_W+1:0] diff;
            diff  = cur - trial;
            n_rem = fit ? diff[REM_W-1:0] : cur[REM_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_s;
            end
            r_side[g] <= side_s;
            r_rad[g]  <= {rad_s[SUM_W-3:0], 2'b00};
            r_root[g] <= {root_s[ROOT_W-2:0], fit};
            r_rem[g]  <= n_rem;
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule
`default_nettype wire

// File: rtl/core/dvn_div.sv
// Pipelined restoring divider for three lanes sharing one divisor:
// q = floor((m * 2^(FRAC_W+32) + L) / 2L). Depends on dvn_pkg.
`default_nettype none
module dvn_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic [SIDE_W-1:0]                    i_side,
    input  wire logic [2:0][dvn_pkg::NORM_W-1:0]      i_mag,
    input  wire logic [dvn_pkg::ROOT_W-1:0]           i_root,
    output logic                                      o_valid,
    output logic [SIDE_W-1:0]                         o_side,
    output logic [2:0][dvn_pkg::QUOT_W-1:0]           o_quot
);
    import dvn_pkg::*;

    localparam int DEN_W = ROOT_W + 1;
    localparam int NST   = QUOT_W + 1;   // set-up stage plus one per quotient bit

    logic                          r_vld  [NST];
    logic [SIDE_W-1:0]             r_side [NST];
    logic [DEN_W-1:0]              r_den  [NST];
    logic [2:0][DEN_W-1:0]         r_rem  [NST];
    logic [2:0][QUOT_W-1:0]        r_qn   [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic                   n_vld;
        logic [SIDE_W-1:0]      n_side;
        logic [DEN_W-1:0]       n_den;
        logic [2:0][DEN_W-1:0]  n_rem;
        logic [2:0][QUOT_W-1:0] n_qn;

        if (g == 0) begin : g_setup
            // Top of the numerator is m * 2^30 plus the high bits of L;
            // the low bits of L shift in one per step.
            always_comb begin
                n_vld  = i_valid;
                n_side = i_side;
                n_den  = {i_root, 1'b0};
                for (int i = 0; i < 3; i++) begin
                    n_rem[i] = DEN_W'({i_mag[i], {TOP_SH{1'b0}}})
                             + DEN_W'(i_root >> QUOT_W);
                    n_qn[i]  = i_root[QUOT_W-1:0];
                end
            end
        end else begin : g_bit
            always_comb begin
                logic [DEN_W:0] t;
                logic [DEN_W:0] d;
                n_vld  = r_vld[g-1];
                n_side = r_side[g-1];
                n_den  = r_den[g-1];
                for (int i = 0; i < 3; i++) begin
                    t = {r_rem[g-1][i], r_qn[g-1][i][QUOT_W-1]};
                    d = t - {1'b0, r_den[g-1]};
                    if (t >= {1'b0, r_den[g-1]}) begin
                        n_rem[i] = d[DEN_W-1:0];
                        n_qn[i]  = {r_qn[g-1][i][QUOT_W-2:0], 1'b1};
                    end else begin
                        n_rem[i] = t[DEN_W-1:0];
                        n_qn[i]  = {r_qn[g-1][i][QUOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= n_vld;
            end
            r_side[g] <= n_side;
            r_den[g]  <= n_den;
            r_rem[g]  <= n_rem;
            r_qn[g]   <= n_qn;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_side  = r_side[NST-1];
    assign o_quot  = r_qn[NST-1];

endmodule
`default_nettype wire

// File: rtl/core/direction_vector_normalizer.sv
// Direction vector normalizer: top level. Uses dvn_pkg, dvn_isqrt and
// dvn_div.
//
// Give an origin and a target point (signed Q15.16) with start; the result
// arrives with o_strobe high for one cycle: the unit direction from origin
// to target in signed Q1.30 (1.0 is 2^30), rounded to nearest. For a plain
// vector give a zero origin. If target equals origin, zero_length is set
// and the components are zero. The pipeline takes one request every cycle
// and busy is never raised; the receiver cannot stall, so nothing waits.
// The pipeline has 6 front stages (difference, magnitude, leading-one search,
// normalising shift, squares, sum), 63 square-root stages (one root bit
// each), one divider set-up stage, 32 divider stages (one quotient bit
// each) and one output register.
`default_nettype none
module direction_vector_normalizer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dvn_pkg::t_req i_req,
    output logic               o_strobe,
    output dvn_pkg::t_res      o_res
);
    import dvn_pkg::*;

    localparam int LATENCY   = 6 + ROOT_W + 1 + QUOT_W + 1;
    localparam int SQ_SIDE_W = 4 + 3 * NORM_W;

    // index of the top set bit, zero for an empty word
    function automatic logic [POS_W-1:0] msb_index(input logic [DIFF_W-1:0] v);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < DIFF_W; b++) begin
            if (v[b]) idx = POS_W'(b);
        end
        return idx;
    endfunction

    logic                       accept;
    logic [COORD_W-1:0]         org [3];
    logic [COORD_W-1:0]         tgt [3];

    logic                       r1_vld;
    logic [DIFF_W-1:0]          r1_d   [3];
    logic                       r2_vld;
    logic [2:0]                 r2_neg;
    logic [DIFF_W-1:0]          r2_mag [3];
    logic                       r3_vld;
    logic [2:0]                 r3_neg;
    logic                       r3_zero;
    logic [POS_W-1:0]           r3_pos;
    logic [DIFF_W-1:0]          r3_mag [3];
    logic                       r4_vld;
    logic [2:0]                 r4_neg;
    logic                       r4_zero;
    logic [2:0][NORM_W-1:0]     r4_m;
    logic                       r5_vld;
    logic [2:0]                 r5_neg;
    logic                       r5_zero;
    logic [2:0][NORM_W-1:0]     r5_m;
    logic [SQ_W-1:0]            r5_sq  [3];
    logic                       r6_vld;
    logic [2:0]                 r6_neg;
    logic                       r6_zero;
    logic [2:0][NORM_W-1:0]     r6_m;
    logic [SUM_W-1:0]           r6_sum;

    logic                       sq_vld;
    logic [SQ_SIDE_W-1:0]       sq_side;
    logic [ROOT_W-1:0]          sq_root;
    logic                       dv_vld;
    logic [3:0]                 dv_side;
    logic [2:0][QUOT_W-1:0]     dv_quot;

    logic                       r_strobe;
    t_res                       r_res;
    t_res                       n_res;

    // the pipeline never holds a request back
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign org[0] = i_req.origin_x;
    assign org[1] = i_req.origin_y;
    assign org[2] = i_req.origin_z;
    assign tgt[0] = i_req.target_x;
    assign tgt[1] = i_req.target_y;
    assign tgt[2] = i_req.target_z;

    // Front stages: exact difference, magnitude, leading-one search,
    // normalising shift so the largest magnitude has its top bit at 30,
    // squares and their sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end

        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= {tgt[i][COORD_W-1], tgt[i]} - {org[i][COORD_W-1], org[i]};
        end

        for (int i = 0; i < 3; i++) begin
            r2_neg[i] <= r1_d[i][DIFF_W-1];
            r2_mag[i] <= r1_d[i][DIFF_W-1] ? (~r1_d[i] + DIFF_W'(1)) : r1_d[i];
        end

        // the top bit of the OR is the top bit of the largest magnitude
        r3_neg  <= r2_neg;
        r3_zero <= ((r2_mag[0] | r2_mag[1] | r2_mag[2]) == '0);
        r3_pos  <= msb_index(r2_mag[0] | r2_mag[1] | r2_mag[2]);
        for (int i = 0; i < 3; i++) begin
            r3_mag[i] <= r2_mag[i];
        end

        // (mag << 30) >> pos covers both the exact left shift and the
        // truncating right shift
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        for (int i = 0; i < 3; i++) begin
            r4_m[i] <= NORM_W'({r3_mag[i], {NORM_TOP{1'b0}}} >> r3_pos);
        end

        r5_neg  <= r4_neg;
        r5_zero <= r4_zero;
        r5_m    <= r4_m;
        for (int i = 0; i < 3; i++) begin
            r5_sq[i] <= SQ_W'(r4_m[i]) * SQ_W'(r4_m[i]);
        end

        r6_neg  <= r5_neg;
        r6_zero <= r5_zero;
        r6_m    <= r5_m;
        r6_sum  <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);
    end

    // Length: floor(sqrt(sum * 2^62)); flags and magnitudes ride alongside.
    dvn_isqrt #(
        .SIDE_W     (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r6_vld),
        .i_side     ({r6_zero, r6_neg, r6_m}),
        .i_radicand (r6_sum),
        .o_valid    (sq_vld),
        .o_side     (sq_side),
        .o_root     (sq_root)
    );

    // Divide each magnitude by the length, rounded to nearest.
    dvn_div #(
        .SIDE_W     (4)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sq_vld),
        .i_side     (sq_side[SQ_SIDE_W-1 -: 4]),
        .i_mag      (sq_side[3*NORM_W-1:0]),
        .i_root     (sq_root),
        .o_valid    (dv_vld),
        .o_side     (dv_side),
        .o_quot     (dv_quot)
    );

    // Output: clamp to 1.0, restore the sign, force zero for a null vector.
    always_comb begin
        logic [QUOT_W-1:0] one;
        logic [QUOT_W-1:0] q;
        logic [UNIT_W-1:0] u [3];
        one = QUOT_W'(1) << FRAC_W;
        for (int i = 0; i < 3; i++) begin
            q    = (dv_quot[i] > one) ? one : dv_quot[i];
            u[i] = dv_side[i] ? UNIT_W'(~q + QUOT_W'(1)) : UNIT_W'(q);
            if (dv_side[3]) u[i] = '0;
        end
        n_res.unit_x      = u[0];
        n_res.unit_y      = u[1];
        n_res.unit_z      = u[2];
        n_res.zero_length = dv_side[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_vld;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // every result traces back to a request a fixed latency earlier
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result without matching request");

    // a null vector gives zero components
    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.zero_length) |->
            (o_res.unit_x == '0 && o_res.unit_y == '0 && o_res.unit_z == '0))
        else $error("zero_length with non-zero components");

    // components stay within plus or minus 1.0
    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            (o_res.unit_x <= $signed(UNIT_W'(1) << FRAC_W)) &&
            (o_res.unit_x >= -$signed(UNIT_W'(1) << FRAC_W)) &&
            (o_res.unit_y <= $signed(UNIT_W'(1) << FRAC_W)) &&
            (o_res.unit_y >= -$signed(UNIT_W'(1) << FRAC_W)) &&
            (o_res.unit_z <= $signed(UNIT_W'(1) << FRAC_W)) &&
            (o_res.unit_z >= -$signed(UNIT_W'(1) << FRAC_W)))
        else $error("unit component out of range");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for direction_vector_normalizer: directed and random requests
// checked against an in-bench predictor of the unit direction arithmetic.
// Depends on dvn_pkg and the direction_vector_normalizer RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvn_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
    localparam int DRAIN_CYCLES   = 150;   // extra wait after the last expected result

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_res  o_res;

    t_res  expected_units[$];  // predicted results, oldest first
    int    errors;
    int    idle_cycles;

    direction_vector_normalizer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Floor square root of a 128-bit value, one root bit at a time.
    function automatic logic [63:0] floor_root(input logic [127:0] n);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq    = 128'(trial) * 128'(trial);
            if (sq <= n) root = trial;
        end
        return root;
    endfunction

    // Predict the unit direction from origin to target.
    function automatic t_res unit_direction(input t_req r);
        t_res                     res;
        logic signed [DIFF_W-1:0] d [3];
        logic [DIFF_W-1:0]        mag [3];
        logic [DIFF_W-1:0]        top;
        logic [63:0]              m [3];
        logic [63:0]              sum_sq;
        logic [63:0]              len;
        logic [127:0]             num;
        logic [63:0]              q;
        int                       p;
        d[0] = DIFF_W'(r.target_x) - DIFF_W'(r.origin_x);
        d[1] = DIFF_W'(r.target_y) - DIFF_W'(r.origin_y);
        d[2] = DIFF_W'(r.target_z) - DIFF_W'(r.origin_z);
        top = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i][DIFF_W-1] ? DIFF_W'(-d[i]) : DIFF_W'(d[i]);
            if (mag[i] > top) top = mag[i];
        end
        res = '0;
        // Target equals origin: flag it and return zero components.
        if (top == 0) begin
            res.zero_length = 1'b1;
            return res;
        end
        p = 0;
        for (int b = 0; b < DIFF_W; b++)
            if (top[b]) p = b;
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (p < 30) ? (64'(mag[i]) << (30 - p)) : (64'(mag[i]) >> (p - 30));
            sum_sq += m[i] * m[i];
        end
        len = floor_root({sum_sq, 64'd0} >> 2);
        for (int i = 0; i < 3; i++) begin
            num = (128'(m[i]) << (FRAC_W + 32)) + 128'(len);
            q   = 64'(num / (128'(len) << 1));
            if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
            if (d[i][DIFF_W-1]) q = -q;
            case (i)
                0: res.unit_x = q[UNIT_W-1:0];
                1: res.unit_y = q[UNIT_W-1:0];
                default: res.unit_z = q[UNIT_W-1:0];
            endcase
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one request, wait for it to be taken, then idle for a random gap, possibly none.
    task automatic send_request(input t_req r, input bit burst);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        expected_units.push_back(unit_direction(r));
        gap = burst ? 0 : gap_length();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_req make_request(input logic [31:0] ox, oy, oz, tx, ty, tz);
        t_req r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.target_x = tx; r.target_y = ty; r.target_z = tz;
        return r;
    endfunction

    // Coincident points, including at the edges of the coordinate range.
    task automatic test_zero_length();
        send_request(make_request(0, 0, 0, 0, 0, 0), 1'b0);
        send_request(make_request(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678), 1'b1);
        send_request(make_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1'b0);
    endtask

    // Axis directions, tiny and huge differences, diagonals.
    task automatic test_directed_vectors();
        send_request(make_request(0, 0, 0, 1, 0, 0), 1'b0);
        send_request(make_request(0, 0, 0, 0, 32'hffff_ffff, 0), 1'b1);
        send_request(make_request(0, 0, 0, 0, 0, 32'h0001_0000), 1'b0);
        // Widest differences in both senses: the full 33-bit range.
        send_request(make_request(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0), 1'b0);
        send_request(make_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1);
        send_request(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
        send_request(make_request(0, 0, 0, 1, 1, 1), 1'b1);
        send_request(make_request(0, 0, 0, 32'hffff_ffff, 1, 32'hffff_ffff), 1'b0);
        send_request(make_request(0, 0, 0, 3, 4, 0), 1'b0);
        send_request(make_request(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0), 1'b1);
        send_request(make_request(0, 0, 0, 32'h7fff_ffff, 1, 0), 1'b0);
        send_request(make_request(0, 0, 0, 32'h4000_0000, 32'h4000_0000, 32'hc000_0000), 1'b0);
        send_request(make_request(32'h1000_0000, 32'hf000_0000, 5,
                                  32'hf000_0000, 32'h1000_0000, 5), 1'b0);
    endtask

    // Random requests: full-range points, nearby points, plain vectors and single-axis or coincident pairs.
    task automatic test_random_requests(input int count);
        t_req r;
        int   kind;
        int   sh;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            r = make_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (kind >= 4 && kind < 8) begin
                // Nearby target: small offsets at a random scale.
                sh = $urandom_range(0, 20);
                r.target_x = r.origin_x + ($signed(32'($urandom_range(0, 15)) - 7) <<< sh);
                r.target_y = r.origin_y + ($signed(32'($urandom_range(0, 15)) - 7) <<< sh);
                r.target_z = r.origin_z + ($signed(32'($urandom_range(0, 15)) - 7) <<< sh);
            end else if (kind == 8) begin
                r.origin_x = '0; r.origin_y = '0; r.origin_z = '0;
            end else if (kind == 9) begin
                // Occasionally coincident, else one axis only.
                r.target_x = r.origin_x;
                r.target_y = r.origin_y;
                if ($urandom_range(0, 3) == 0) r.target_z = r.origin_z;
            end
            send_request(r, $urandom_range(0, 3) == 0);
        end
        start <= 1'b0;
    endtask

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (expected_units.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = expected_units.pop_front();
                if (o_res.unit_x !== want.unit_x) begin
                    $error("unit_x: expected %0d, got %0d", want.unit_x, o_res.unit_x);
                    errors++;
                end
                if (o_res.unit_y !== want.unit_y) begin
                    $error("unit_y: expected %0d, got %0d", want.unit_y, o_res.unit_y);
                    errors++;
                end
                if (o_res.unit_z !== want.unit_z) begin
                    $error("unit_z: expected %0d, got %0d", want.unit_z, o_res.unit_z);
                    errors++;
                end
                if (o_res.zero_length !== want.zero_length) begin
                    $error("zero_length: expected %0b, got %0b",
                           want.zero_length, o_res.zero_length);
                    errors++;
                end
            end
        end
    end

    // Watchdog: advance a count while neither side moves anything.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        errors      = 0;
        idle_cycles = 0;
        start       = 1'b0;
        i_req       = '0;
        i_rst_n     = 1'b0;
        // Hold reset from the start, then release it at an edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_directed_vectors();
        test_random_requests(734);

        // Drain the pipeline, then allow a little extra for stray strobes.
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
